[src/hqp_pkg.sv]
`default_nettype none

package hqp_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int SIZE_W   = 7;
    localparam int COUNT_W  = 7;

    localparam int KEY_DATA_W = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic load;
        logic mod_start;
        logic probe_init;
        logic probe_step;
        logic simple;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic probe_op;
        logic mod_done;
        logic probe_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[src/hash_table_quadratic_probe.sv]
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  tuser: kind; tdata: key
// m_        out        m_tvalid/m_tready  tuser: status; tdata: slot_index, occupied_count
// cfg_      in         cfg_we             cfg_wdata: table_size
//
// Insert/search: accept, decode, key mod size (one key bit a cycle in the
// remainder unit), setup, then the probe steps (the last one finds a free slot,
// a hit or the path used up; on search the key read is registered), then the result is loaded.
// Clear and unused kinds skip the remainder and probe steps. Clear drops all used flags at once.
// Reset is synchronous, active low; slot flags and the count are cleared at once.
// A new item is taken while the previous result waits in the output register.
module hash_table_quadratic_probe #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [hqp_pkg::SIZE_W-1:0]       cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [hqp_pkg::KEY_DATA_W-1:0]   s_tdata,   // [30:0] key
    input  wire logic [hqp_pkg::KIND_W-1:0]       s_tuser,   // [1:0] kind
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [hqp_pkg::OUT_DATA_W-1:0]        m_tdata,   // [5:0] slot_index, [12:6] occupied_count
    output logic [hqp_pkg::STATUS_W-1:0]          m_tuser    // [2:0] status
);
    import hqp_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [SLOT_W-1:0]   out_slot;
    logic [COUNT_W-1:0]  out_count;

    hqp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hqp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_kind    (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_count  (out_count)
    );

    assign m_tdata = {{(OUT_DATA_W - SLOT_W - COUNT_W){1'b0}}, out_count, out_slot};

endmodule

`default_nettype wire

[src/hqp_mod.sv]
`default_nettype none

// Restoring remainder, one key bit per cycle, MSB first.
module hqp_mod (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [hqp_pkg::KEY_W-1:0]  dividend,
    input  wire logic [hqp_pkg::SIZE_W-1:0] divisor,
    output logic                            done,
    output logic [hqp_pkg::SIZE_W-1:0]      remainder
);
    import hqp_pkg::*;

    localparam int CW = $clog2(KEY_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [KEY_W-1:0]    dvd_reg, dvd_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W:0]     trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[KEY_W-1]};
        if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(KEY_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = trial[SIZE_W-1:0];
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[src/hqp_datapath.sv]
`default_nettype none

module hqp_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [hqp_pkg::SIZE_W-1:0]   cfg_wdata,
    input  wire logic [hqp_pkg::KIND_W-1:0]   in_kind,
    input  wire logic [hqp_pkg::KEY_W-1:0]    in_key,
    input  wire hqp_pkg::cmd_t                cmd,
    output hqp_pkg::stat_t                    stat,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [hqp_pkg::STATUS_W-1:0]      out_status,
    output logic [hqp_pkg::SLOT_W-1:0]        out_slot,
    output logic [hqp_pkg::COUNT_W-1:0]       out_count
);
    import hqp_pkg::*;

    // Only slots below the 7-bit size can ever be probed.
    localparam int SIZE_LIMIT = 2 ** SIZE_W;
    localparam int USE_DEPTH  = (TABLE_DEPTH > SIZE_LIMIT) ? SIZE_LIMIT : TABLE_DEPTH;
    localparam int AW         = $clog2(USE_DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        (TABLE_DEPTH > SIZE_LIMIT - 1) ? SIZE_W'(SIZE_LIMIT - 1) : SIZE_W'(TABLE_DEPTH);

    function automatic logic [SIZE_W-1:0] add_mod(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b,
                                                  input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[SIZE_W-1:0];
    endfunction

    logic [SIZE_W-1:0]   tsize_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SIZE_W-1:0]   n;
    logic [SIZE_W-1:0]   two_mod;

    logic                mod_done;
    logic [SIZE_W-1:0]   home;

    logic [SIZE_W-1:0]   s_reg, d_reg, i_reg;
    logic                stg_valid_reg, stg_used_reg;
    logic [SIZE_W-1:0]   stg_slot_reg;
    logic [KEY_W-1:0]    rd_reg;
    logic [KEY_W-1:0]    key_mem [USE_DEPTH];
    logic [USE_DEPTH-1:0] used_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [SIZE_W-1:0]   res_slot_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [AW-1:0]       addr;
    logic                cur_used, issue, is_insert, hit, probe_done, mem_we;

    always_comb begin
        if (tsize_reg == '0) begin
            n = SIZE_W'(1);
        end else if (tsize_reg > SIZE_CAP) begin
            n = SIZE_CAP;
        end else begin
            n = tsize_reg;
        end
        two_mod = (n <= SIZE_W'(2)) ? '0 : SIZE_W'(2);
    end

    hqp_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (key_reg),
        .divisor   (n),
        .done      (mod_done),
        .remainder (home)
    );

    assign addr      = s_reg[AW-1:0];
    assign cur_used  = used_reg[addr];
    assign issue     = (i_reg != n);
    assign is_insert = (kind_reg == KIND_INSERT);
    assign hit       = stg_valid_reg && stg_used_reg && (rd_reg == key_reg);
    assign mem_we    = cmd.probe_step && is_insert && issue && !cur_used;

    always_comb begin
        if (is_insert) begin
            probe_done = !issue || !cur_used;
        end else begin
            probe_done = hit || (!issue && !stg_valid_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[addr] <= key_reg;
        end
        rd_reg <= key_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsize_reg     <= SIZE_RESET;
            used_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tsize_reg <= cfg_wdata;
            end
            if (mem_we) begin
                used_reg[addr] <= 1'b1;
                count_reg      <= count_reg + 1'b1;
            end
            if (cmd.simple && kind_reg == KIND_CLEAR) begin
                used_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            key_reg  <= in_key;
        end
        if (cmd.probe_init) begin
            s_reg         <= home;
            d_reg         <= two_mod;
            i_reg         <= '0;
            stg_valid_reg <= 1'b0;
        end else if (cmd.probe_step) begin
            stg_valid_reg <= issue;
            stg_slot_reg  <= s_reg;
            stg_used_reg  <= cur_used;
            if (issue) begin
                s_reg <= add_mod(s_reg, d_reg, n);
                d_reg <= add_mod(d_reg, two_mod, n);
                i_reg <= i_reg + 1'b1;
            end
        end
        if (cmd.probe_step && probe_done) begin
            if (is_insert) begin
                res_status_reg <= issue ? ST_INSERTED : ST_FULL;
                res_slot_reg   <= issue ? s_reg : '0;
            end else begin
                res_status_reg <= hit ? ST_HIT : ST_MISS;
                res_slot_reg   <= hit ? stg_slot_reg : '0;
            end
        end
        if (cmd.simple) begin
            res_status_reg <= (kind_reg == KIND_CLEAR) ? ST_CLEARED : ST_MISS;
            res_slot_reg   <= '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg[SLOT_W-1:0];
            out_count_reg  <= count_reg;
        end
    end

    always_comb begin
        stat.probe_op   = (kind_reg == KIND_INSERT) || (kind_reg == KIND_SEARCH);
        stat.mod_done   = mod_done;
        stat.probe_done = probe_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

[src/hqp_ctrl.sv]
`default_nettype none

module hqp_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hqp_pkg::stat_t stat,
    output hqp_pkg::cmd_t       cmd
);
    import hqp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_DIV    = 5'b00100,
        S_PROBE  = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.probe_op) begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.simple = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                if (stat.mod_done) begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE: begin
                cmd.probe_step = 1'b1;
                if (stat.probe_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // output register frees up while the previous item drains
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[verif/tb_hash_table_quadratic_probe.sv]
`default_nettype none

module tb_hash_table_quadratic_probe;
    import hqp_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 700;
    localparam int SEGMENT_ITEMS  = 65;
    localparam int DIRECTED_ROWS  = 28;

    // kind 3 has no meaning in the block; it must answer a miss and change nothing
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } op_result_t;

    typedef struct packed {
        logic                is_cfg;
        logic [SIZE_W-1:0]   size;
        logic [KIND_W-1:0]   kind;
        logic [KEY_W-1:0]    key;
        logic                typed;
        op_result_t          want;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [SIZE_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [KEY_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // shadow of the table
    logic [KEY_W-1:0]   shadow_key  [TABLE_DEPTH];
    logic               shadow_used [TABLE_DEPTH];
    logic [COUNT_W-1:0] shadow_count;
    logic [SIZE_W-1:0]  shadow_size;

    op_result_t       results_due [$];
    logic [KEY_W-1:0] stored_keys [$];
    plan_row_t        directed [DIRECTED_ROWS];

    int  errors;
    int  items_sent;
    int  n_inserted, n_full, n_hit, n_miss, n_cleared;
    int  src_idle_pct;
    int  dst_idle_pct;
    bit  hold_req;
    int  quiet_cycles;

    hash_table_quadratic_probe #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Insert/search/clear on the shadow table; returns what the block must answer.
    function automatic op_result_t apply_table_op(input logic [KIND_W-1:0] kind,
                                                  input logic [KEY_W-1:0] key);
        op_result_t  r;
        int unsigned n;
        int unsigned home;
        int unsigned s;
        int unsigned i;
        n = (shadow_size == 0) ? 1 : ((shadow_size > TABLE_DEPTH) ? TABLE_DEPTH : shadow_size);
        home = key % n;
        r.status = ST_MISS;
        r.slot   = '0;
        case (kind)
            KIND_INSERT: begin
                r.status = ST_FULL;
                for (i = 0; i < n; i++) begin
                    s = (home + i + i * i) % n;
                    if (!shadow_used[s]) begin
                        shadow_key[s]  = key;
                        shadow_used[s] = 1'b1;
                        shadow_count   = shadow_count + 1'b1;
                        r.status = ST_INSERTED;
                        r.slot   = s[SLOT_W-1:0];
                        break;
                    end
                end
            end
            KIND_SEARCH: begin
                for (i = 0; i < n; i++) begin
                    s = (home + i + i * i) % n;
                    if (shadow_used[s] && shadow_key[s] == key) begin
                        r.status = ST_HIT;
                        r.slot   = s[SLOT_W-1:0];
                        break;
                    end
                end
            end
            KIND_CLEAR: begin
                for (i = 0; i < TABLE_DEPTH; i++)
                    shadow_used[i] = 1'b0;
                shadow_count = '0;
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [SIZE_W-1:0] size);
        plan_row_t p;
        p = '0;
        p.is_cfg = 1'b1;
        p.size   = size;
        return p;
    endfunction

    function automatic plan_row_t op_row(input logic [KIND_W-1:0] kind,
                                         input logic [KEY_W-1:0] key);
        plan_row_t p;
        p = '0;
        p.kind = kind;
        p.key  = key;
        return p;
    endfunction

    function automatic plan_row_t known_row(input logic [KIND_W-1:0] kind,
                                            input logic [KEY_W-1:0] key,
                                            input logic [STATUS_W-1:0] status,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [COUNT_W-1:0] count);
        plan_row_t p;
        p = op_row(kind, key);
        p.typed       = 1'b1;
        p.want.status = status;
        p.want.slot   = slot;
        p.want.count  = count;
        return p;
    endfunction

    // Offers one item; valid stays high on return so back-to-back items need no gap.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                             input logic typed, input op_result_t want);
        op_result_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, key};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_table_op(kind, key);
        results_due.push_back(typed ? want : predicted);
        items_sent++;
        if (kind == KIND_INSERT) begin
            stored_keys.push_back(key);
            if (stored_keys.size() > 80)
                void'(stored_keys.pop_front());
        end
    endtask

    task automatic wait_table_idle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_table_size(input logic [SIZE_W-1:0] size);
        wait_table_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        shadow_size = size;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_segment(input int count);
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        int unsigned       pick;
        int unsigned       n;
        op_result_t        none;
        none = '0;
        n = (shadow_size == 0) ? 1 : shadow_size;
        repeat (count) begin
            pick = $urandom_range(99);
            key  = ($urandom_range(99) < 35)
                   ? KEY_W'(n * $urandom_range(0, 40) + $urandom_range(0, 3))
                   : KEY_W'($urandom());
            if (pick < 2)
                kind = KIND_CLEAR;
            else if (pick < 5)
                kind = KIND_UNUSED;
            else if (pick < 52)
                kind = KIND_INSERT;
            else begin
                kind = KIND_SEARCH;
                // mostly look up keys that were stored, so hits dominate
                if (pick < 82 && stored_keys.size() != 0)
                    key = stored_keys[$urandom_range(stored_keys.size() - 1)];
            end
            send_item(kind, key, 1'b0, none);
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin : sink
        int unsigned hold_left;
        bit          hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        op_result_t due;
        op_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.slot   = m_tdata[5:0];
            got.count  = m_tdata[12:6];
            case (got.status)
                ST_INSERTED: n_inserted++;
                ST_FULL:     n_full++;
                ST_HIT:      n_hit++;
                ST_MISS:     n_miss++;
                ST_CLEARED:  n_cleared++;
                default: ;
            endcase
            if (results_due.size() == 0) begin
                $error("unexpected item: status %0d slot %0d count %0d",
                       got.status, got.slot, got.count);
                errors++;
            end else begin
                due = results_due.pop_front();
                if (got.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, got.status);
                    errors++;
                end
                if (got.slot !== due.slot) begin
                    $error("slot_index: expected %0d, got %0d", due.slot, got.slot);
                    errors++;
                end
                if (got.count !== due.count) begin
                    $error("occupied_count: expected %0d, got %0d", due.count, got.count);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int         row;
        int         phase;
        int         seg;
        logic [SIZE_W-1:0] size_menu [12];
        size_menu = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd5, 7'd17, 7'd63,
                      7'd3, 7'd40, 7'd64, 7'd8};

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_key[i]  = '0;
            shadow_used[i] = 1'b0;
        end
        shadow_count = '0;
        shadow_size  = SIZE_RESET;

        directed = '{
            known_row(KIND_SEARCH, 31'd5, ST_MISS, 6'd0, 7'd0),
            known_row(KIND_INSERT, 31'd0, ST_INSERTED, 6'd0, 7'd1),
            known_row(KIND_INSERT, 31'h7FFF_FFFF, ST_INSERTED, 6'd63, 7'd2),
            known_row(KIND_SEARCH, 31'h7FFF_FFFF, ST_HIT, 6'd63, 7'd2),
            op_row(KIND_INSERT, 31'd64),             // collides with slot 0
            op_row(KIND_INSERT, 31'd128),
            op_row(KIND_SEARCH, 31'd128),
            known_row(KIND_UNUSED, 31'h5555_5555, ST_MISS, 6'd0, 7'd4),
            known_row(KIND_CLEAR, 31'h2AAA_AAAA, ST_CLEARED, 6'd0, 7'd0),
            known_row(KIND_SEARCH, 31'd0, ST_MISS, 6'd0, 7'd0),   // stale key, flag cleared
            cfg_row(7'd1),
            known_row(KIND_INSERT, 31'h2AAA_AAAA, ST_INSERTED, 6'd0, 7'd1),
            known_row(KIND_INSERT, 31'd7, ST_FULL, 6'd0, 7'd1),
            known_row(KIND_SEARCH, 31'h2AAA_AAAA, ST_HIT, 6'd0, 7'd1),
            cfg_row(7'd0),                           // behaves as size 1
            known_row(KIND_INSERT, 31'd3, ST_FULL, 6'd0, 7'd1),
            cfg_row(7'd127),                         // clamps to full depth
            op_row(KIND_INSERT, 31'h4000_0000),
            op_row(KIND_SEARCH, 31'h2AAA_AAAA),
            cfg_row(7'd3),                           // probe path skips a slot
            op_row(KIND_INSERT, 31'd9),
            op_row(KIND_INSERT, 31'd10),
            op_row(KIND_INSERT, 31'd11),
            op_row(KIND_INSERT, 31'd12),
            op_row(KIND_SEARCH, 31'd11),
            cfg_row(7'd64),                          // keys stored before the shrink are kept
            op_row(KIND_SEARCH, 31'h4000_0000),
            known_row(KIND_CLEAR, 31'd0, ST_CLEARED, 6'd0, 7'd0)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed[row].is_cfg)
                set_table_size(directed[row].size);
            else
                send_item(directed[row].kind, directed[row].key,
                          directed[row].typed, directed[row].want);
        end

        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 65 : 0;
            dst_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 33 : 0;
            for (seg = 0; seg < 4; seg++) begin
                set_table_size(size_menu[phase * 4 + seg]);
                run_segment(SEGMENT_ITEMS);
            end
        end

        // long result-side hold-off while items keep coming: input must back up
        set_table_size(7'd4);
        hold_req <= ~hold_req;
        run_segment(12);

        wait_table_idle();
        repeat (120) @(posedge aclk);

        $display("covered %0d items over sizes 0..127 with random stalls and a long hold-off",
                 items_sent);
        $display("results: %0d inserted, %0d full, %0d hit, %0d miss, %0d cleared",
                 n_inserted, n_full, n_hit, n_miss, n_cleared);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
